/* hdl/hex_flood_fill_area_macros.svh */
// Assertion macros for the hex flood fill area meter.
`ifndef HEX_FLOOD_FILL_AREA_MACROS_SVH
`define HEX_FLOOD_FILL_AREA_MACROS_SVH

`ifndef SYNTH
`define HFFA_CHECK(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);
`define HFFA_IMPLY(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);
`else
`define HFFA_CHECK(lbl, cond, msg)
`define HFFA_IMPLY(lbl, pre, post, msg)
`endif

`endif

/* hdl/hffa_pkg.sv */
// Shared constants, types and helper functions of the hex flood fill area meter.
package hffa_pkg;

    localparam int MAX_RADIUS   = 7;
    localparam int SIDE         = 2 * MAX_RADIUS + 1;
    localparam int SQUARE_CELLS = SIDE * SIDE;
    localparam int HEX_CELLS    = 3 * MAX_RADIUS * (MAX_RADIUS + 1) + 1;

    localparam int ADDR_W  = $clog2(SQUARE_CELLS);
    localparam int QPTR_W  = $clog2(HEX_CELLS + 1);
    localparam int COORD_W = 4;
    localparam int POS_W   = COORD_W + 1;
    localparam int LEVEL_W = 16;
    localparam int RAD_W   = 3;
    localparam int CNT_W   = 8;
    localparam int QENT_W  = 2 * COORD_W;

    localparam logic [0:0] ACT_LOAD  = 1'b0;
    localparam logic [0:0] ACT_START = 1'b1;

    localparam logic [0:0] CFG_LEVEL_THRESHOLD = 1'b0;
    localparam logic [0:0] CFG_SEARCH_RADIUS   = 1'b1;

    localparam logic signed [LEVEL_W-1:0] THRESHOLD_RST = -16'sd3277;
    localparam logic [RAD_W-1:0]          RADIUS_RST    = 3'd4;

    localparam logic [COORD_W-1:0] COORD_BIAS = COORD_W'(MAX_RADIUS);
    localparam logic [COORD_W-1:0] COORD_BAD  = {1'b1, {(COORD_W-1){1'b0}}};

    typedef logic [2:0] t_dir;
    localparam t_dir DIR_FIRST = 3'd0;
    localparam t_dir DIR_LAST  = 3'd5;
    localparam t_dir DIR_SELF  = 3'd6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_CHECK,
        ST_COMPARE,
        ST_POP,
        ST_FETCH,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic              in_hex;
        logic              on_ring;
        logic [ADDR_W-1:0] addr;
    } t_geom;

    typedef struct packed {
        logic              done;
        logic [QPTR_W-1:0] head;
        logic [QPTR_W-1:0] tail;
        logic [CNT_W-1:0]  count;
    } t_stat;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [COORD_W-1:0] bx,
                                                    input logic [COORD_W-1:0] bz);
        logic [ADDR_W-1:0] row;
        row = (ADDR_W'(bx) << COORD_W) - ADDR_W'(bx);
        return row + ADDR_W'(bz);
    endfunction

    function automatic logic signed [POS_W-1:0] step_dx(input t_dir d);
        case (d)
            3'd0:    return -5'sd1;
            3'd1:    return 5'sd1;
            3'd4:    return -5'sd1;
            3'd5:    return 5'sd1;
            default: return 5'sd0;
        endcase
    endfunction

    function automatic logic signed [POS_W-1:0] step_dz(input t_dir d);
        case (d)
            3'd2:    return -5'sd1;
            3'd3:    return 5'sd1;
            3'd4:    return 5'sd1;
            3'd5:    return -5'sd1;
            default: return 5'sd0;
        endcase
    endfunction

endpackage

/* hdl/hffa_ram.sv */
// Generic single write port RAM with one registered read port.
module hffa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/hffa_geom.sv */
// Hex distance, ring test and store address of one axial cell.
module hffa_geom
    import hffa_pkg::*;
(
    input  logic signed [POS_W-1:0] i_x,
    input  logic signed [POS_W-1:0] i_z,
    input  logic [RAD_W-1:0]        i_radius,
    output t_geom                   o_geom
);

    logic [POS_W-1:0]        w_ax;
    logic [POS_W-1:0]        w_az;
    logic signed [POS_W:0]   w_sum;
    logic [POS_W:0]          w_as;
    logic [POS_W:0]          w_dist;
    logic [COORD_W-1:0]      w_bx;
    logic [COORD_W-1:0]      w_bz;

    always_comb begin
        w_ax   = i_x[POS_W-1] ? POS_W'(-i_x) : POS_W'(i_x);
        w_az   = i_z[POS_W-1] ? POS_W'(-i_z) : POS_W'(i_z);
        w_sum  = (POS_W+1)'(i_x) + (POS_W+1)'(i_z);
        w_as   = w_sum[POS_W] ? (POS_W+1)'(-w_sum) : (POS_W+1)'(w_sum);
        w_dist = {1'b0, w_ax};
        if ({1'b0, w_az} > w_dist) begin
            w_dist = {1'b0, w_az};
        end
        if (w_as > w_dist) begin
            w_dist = w_as;
        end
        w_bx = i_x[COORD_W-1:0] + COORD_BIAS;
        w_bz = i_z[COORD_W-1:0] + COORD_BIAS;
        o_geom.in_hex  = w_dist <= (POS_W+1)'(i_radius);
        o_geom.on_ring = w_dist == (POS_W+1)'(i_radius);
        o_geom.addr    = cell_addr(w_bx, w_bz);
    end

endmodule

/* hdl/hffa_ctrl.sv */
// Load and breadth-first search sequencer with the sample store and cell queue.
module hffa_ctrl
    import hffa_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [0:0]                i_action,
    input  logic signed [COORD_W-1:0] i_cell_x,
    input  logic signed [COORD_W-1:0] i_cell_z,
    input  logic signed [LEVEL_W-1:0] i_sample_level,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [CNT_W-1:0]          o_cell_count,
    output logic                      o_touches_edge,
    input  logic signed [LEVEL_W-1:0] i_threshold,
    input  logic [RAD_W-1:0]          i_radius,
    output t_stat                     o_stat
);

    t_state                    r_state;
    t_state                    n_state;
    t_dir                      r_dir;
    logic signed [POS_W-1:0]   r_cx;
    logic signed [POS_W-1:0]   r_cz;
    logic [QPTR_W-1:0]         r_head;
    logic [QPTR_W-1:0]         r_tail;
    logic [CNT_W-1:0]          r_count;
    logic                      r_edge;
    logic [ADDR_W-1:0]         r_clr;
    logic [ADDR_W-1:0]         r_cand_addr;
    logic [QENT_W-1:0]         r_cand_q;
    logic                      r_out_valid;
    logic [CNT_W-1:0]          r_out_count;
    logic                      r_out_edge;

    logic [RAD_W-1:0]          w_radius;
    logic signed [POS_W-1:0]   w_nx;
    logic signed [POS_W-1:0]   w_nz;
    t_geom                     w_cand;
    t_geom                     w_pop;
    logic                      w_look;
    logic                      w_take;
    logic                      w_below;
    logic                      w_fire;
    logic                      w_adv;
    logic                      w_out_free;
    logic signed [POS_W-1:0]   w_fx;
    logic signed [POS_W-1:0]   w_fz;
    t_dir                      w_dir_next;

    logic                      w_smp_we;
    logic [ADDR_W-1:0]         w_smp_waddr;
    logic signed [LEVEL_W-1:0] w_smp_rdata;
    logic                      w_q_we;
    logic [QENT_W-1:0]         w_q_rdata;
    logic                      w_vis_we;
    logic [ADDR_W-1:0]         w_vis_waddr;
    logic                      w_vis_wdata;
    logic                      w_vis_rdata;

    assign w_radius = (i_radius == '0) ? RAD_W'(1) : i_radius;
    assign w_nx     = r_cx + step_dx(r_dir);
    assign w_nz     = r_cz + step_dz(r_dir);
    assign w_fx     = $signed({1'b0, w_q_rdata[QENT_W-1:COORD_W]}) - POS_W'(MAX_RADIUS);
    assign w_fz     = $signed({1'b0, w_q_rdata[COORD_W-1:0]}) - POS_W'(MAX_RADIUS);

    hffa_geom u_cand_geom (
        .i_x      (w_nx),
        .i_z      (w_nz),
        .i_radius (w_radius),
        .o_geom   (w_cand)
    );

    hffa_geom u_pop_geom (
        .i_x      (w_fx),
        .i_z      (w_fz),
        .i_radius (w_radius),
        .o_geom   (w_pop)
    );

    // sample writes only in idle, reads only during search: no overlap
    hffa_ram #(
        .WIDTH (LEVEL_W),
        .DEPTH (SQUARE_CELLS)
    ) u_sample_ram (
        .i_clk   (i_clk),
        .i_we    (w_smp_we),
        .i_waddr (w_smp_waddr),
        .i_wdata (i_sample_level),
        .i_raddr (w_cand.addr),
        .o_rdata (w_smp_rdata)
    );

    // lookups issue in check, marks land in compare: a mark is in place before the next lookup
    hffa_ram #(
        .WIDTH (1),
        .DEPTH (SQUARE_CELLS)
    ) u_visited_ram (
        .i_clk   (i_clk),
        .i_we    (w_vis_we),
        .i_waddr (w_vis_waddr),
        .i_wdata (w_vis_wdata),
        .i_raddr (w_cand.addr),
        .o_rdata (w_vis_rdata)
    );

    // queue pushes and pops happen in different states
    hffa_ram #(
        .WIDTH (QENT_W),
        .DEPTH (HEX_CELLS)
    ) u_queue_ram (
        .i_clk   (i_clk),
        .i_we    (w_q_we),
        .i_waddr (r_tail),
        .i_wdata (r_cand_q),
        .i_raddr (r_head),
        .o_rdata (w_q_rdata)
    );

    // outputs and datapath strobes
    always_comb begin
        o_ready     = r_state == ST_IDLE;
        w_fire      = o_ready && i_valid;
        w_smp_waddr = cell_addr(i_cell_x + COORD_BIAS, i_cell_z + COORD_BIAS);
        w_smp_we    = w_fire && (i_action == ACT_LOAD) &&
                      (i_cell_x != COORD_BAD) && (i_cell_z != COORD_BAD);
        w_look      = (r_state == ST_CHECK) && w_cand.in_hex;
        w_below     = w_smp_rdata < i_threshold;
        w_take      = (r_state == ST_COMPARE) && !w_vis_rdata && w_below;
        w_q_we      = w_take;
        w_vis_we    = (r_state == ST_CLEAR) || w_take;
        w_vis_waddr = (r_state == ST_CLEAR) ? r_clr : r_cand_addr;
        w_vis_wdata = r_state != ST_CLEAR;
        w_adv       = ((r_state == ST_CHECK) && !w_look) || (r_state == ST_COMPARE);
        w_dir_next  = (r_dir == DIR_SELF) ? DIR_FIRST : r_dir + 3'd1;
        w_out_free  = !r_out_valid || i_ready;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_fire && (i_action == ACT_START)) begin
                    n_state = ST_CLEAR;
                end
            end
            ST_CLEAR: begin
                if (r_clr == ADDR_W'(SQUARE_CELLS - 1)) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (w_look) begin
                    n_state = ST_COMPARE;
                end else if (r_dir == DIR_LAST) begin
                    n_state = ST_POP;
                end
            end
            ST_COMPARE: begin
                n_state = (r_dir == DIR_LAST) ? ST_POP : ST_CHECK;
            end
            ST_POP: begin
                n_state = (r_head == r_tail) ? ST_DONE : ST_FETCH;
            end
            ST_FETCH: begin
                n_state = ST_CHECK;
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_dir       <= DIR_SELF;
            r_cx        <= '0;
            r_cz        <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_edge      <= 1'b0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == ST_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_adv) begin
                r_dir <= w_dir_next;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_fire && (i_action == ACT_START)) begin
                        r_clr   <= '0;
                        r_head  <= '0;
                        r_tail  <= '0;
                        r_count <= '0;
                        r_edge  <= 1'b0;
                        r_cx    <= '0;
                        r_cz    <= '0;
                        r_dir   <= DIR_SELF;
                    end
                end
                ST_CLEAR: begin
                    r_clr <= r_clr + ADDR_W'(1);
                end
                ST_CHECK: begin
                    if (w_look) begin
                        r_cand_addr <= w_cand.addr;
                        r_cand_q    <= {w_nx[COORD_W-1:0] + COORD_BIAS,
                                        w_nz[COORD_W-1:0] + COORD_BIAS};
                    end
                end
                ST_COMPARE: begin
                    if (w_take) begin
                        r_tail <= r_tail + QPTR_W'(1);
                    end
                end
                ST_POP: begin
                    if (r_head != r_tail) begin
                        r_head <= r_head + QPTR_W'(1);
                    end
                end
                ST_FETCH: begin
                    r_cx    <= w_fx;
                    r_cz    <= w_fz;
                    r_count <= r_count + CNT_W'(1);
                    r_edge  <= r_edge | w_pop.on_ring;
                    r_dir   <= DIR_FIRST;
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        r_out_count <= r_count;
                        r_out_edge  <= r_edge;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_valid        = r_out_valid;
    assign o_cell_count   = r_out_count;
    assign o_touches_edge = r_out_edge;

    assign o_stat.done  = r_state == ST_DONE;
    assign o_stat.head  = r_head;
    assign o_stat.tail  = r_tail;
    assign o_stat.count = r_count;

endmodule

/* hdl/hex_flood_fill_area.sv */
// Top level of the hex flood fill area meter: configuration, stream packing, checks.
//
//  channel  dir  handshake               payload
//  s        in   s_tvalid / s_tready     tdata: cell_x, cell_z, sample_level; tuser: action
//  m        out  m_tvalid / m_tready     tdata: cell_count, touches_edge
//  cfg      in   i_cfg_we                i_cfg_idx, i_cfg_wdata
//
//  A start first clears the visited map, all 225 entries, then runs the neighbour lookups
//  (7 seed lookups, then 6 per cell). One lookup at a time goes through the sample memory.
//  Reset is synchronous and clears no memory; inputs are refused during a search, and a
//  finished result waits in the output register, holding the search while it is full.
`include "hex_flood_fill_area_macros.svh"

module hex_flood_fill_area
    import hffa_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [23:0]         s_tdata,      // cell_x[3:0], cell_z[7:4], sample_level[23:8]
    input  logic [0:0]          s_tuser,      // action[0]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [15:0]         m_tdata,      // cell_count[7:0], touches_edge[8], zero[15:9]
    input  logic                i_cfg_we,
    input  logic [0:0]          i_cfg_idx,
    input  logic [LEVEL_W-1:0]  i_cfg_wdata
);

    logic signed [LEVEL_W-1:0] r_threshold;
    logic [RAD_W-1:0]          r_radius;
    logic [CNT_W-1:0]          w_count;
    logic                      w_edge;
    t_stat                     w_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RST;
            r_radius    <= RADIUS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LEVEL_THRESHOLD: r_threshold <= i_cfg_wdata;
                CFG_SEARCH_RADIUS:   r_radius    <= i_cfg_wdata[RAD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    hffa_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (s_tvalid),
        .o_ready        (s_tready),
        .i_action       (s_tuser),
        .i_cell_x       (s_tdata[3:0]),
        .i_cell_z       (s_tdata[7:4]),
        .i_sample_level (s_tdata[23:8]),
        .o_valid        (m_tvalid),
        .i_ready        (m_tready),
        .o_cell_count   (w_count),
        .o_touches_edge (w_edge),
        .i_threshold    (r_threshold),
        .i_radius       (r_radius),
        .o_stat         (w_stat)
    );

    assign m_tdata = {7'd0, w_edge, w_count};

    `HFFA_CHECK(a_queue_order, w_stat.head <= w_stat.tail, "queue head passed tail")
    `HFFA_CHECK(a_queue_bound, w_stat.tail <= QPTR_W'(HEX_CELLS), "queue overflow")
    `HFFA_IMPLY(a_count_done, w_stat.done, w_stat.count == w_stat.tail, "count mismatch")
    `HFFA_IMPLY(a_result_src, $rose(m_tvalid), $past(w_stat.done), "result without search")

endmodule
